// ===== hw/rtl/atc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atc_pkg
// Shared types and constants for the allocation trace checker.
// ----------------------------------------------------------------------------
package atc_pkg;

  // default number of allocation table entries
  localparam int TABLE_DEPTH_DEF = 64;

  // field widths
  localparam int WORD_W   = 64;
  localparam int OP_W     = 3;
  localparam int DOMAIN_W = 3;
  localparam int STATUS_W = 4;
  localparam int COUNT_W  = 7;

  // opcodes
  localparam logic [OP_W-1:0] OP_ALLOC   = 3'd0;
  localparam logic [OP_W-1:0] OP_FREE    = 3'd1;
  localparam logic [OP_W-1:0] OP_REALLOC = 3'd2;
  localparam logic [OP_W-1:0] OP_MAX     = 3'd6;

  // highest legal memory domain code
  localparam logic [DOMAIN_W-1:0] DOMAIN_MAX = 3'd5;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK               = 4'd0,
    ST_ID_ZERO          = 4'd1,
    ST_BAD_OP           = 4'd2,
    ST_BAD_DOMAIN       = 4'd3,
    ST_BAD_ALIGN        = 4'd4,
    ST_DUPLICATE        = 4'd5,
    ST_FREE_NOT_LIVE    = 4'd6,
    ST_REALLOC_NOT_LIVE = 4'd7,
    ST_TABLE_FULL       = 4'd8,
    ST_SKIPPED          = 4'd9
  } status_t;

  // one allocation table entry as stored in memory
  typedef struct packed {
    logic              valid;
    logic [WORD_W-1:0] id;
    logic [WORD_W-1:0] size;
  } entry_t;

  // control sequencer states
  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_CLEAR,
    S_EVAL,
    S_SCAN,
    S_DECIDE,
    S_RESP
  } state_t;

endpackage

// ===== hw/rtl/atc_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atc_ifs
// Valid/ready channels for trace entries and check results.
// ----------------------------------------------------------------------------

// trace entry channel
interface atc_in_if;
  logic                                valid;
  logic                                ready;
  logic                                start_of_trace;
  logic [atc_pkg::OP_W-1:0]            opcode;
  logic [atc_pkg::WORD_W-1:0]          alloc_id;
  logic [atc_pkg::WORD_W-1:0]          block_size;
  logic [atc_pkg::WORD_W-1:0]          align_bytes;
  logic [atc_pkg::DOMAIN_W-1:0]        memory_domain;

  modport source (
    output valid, start_of_trace, opcode, alloc_id, block_size, align_bytes,
           memory_domain,
    input  ready
  );
  modport sink (
    input  valid, start_of_trace, opcode, alloc_id, block_size, align_bytes,
           memory_domain,
    output ready
  );
endinterface

// check result channel
interface atc_out_if;
  logic                                valid;
  logic                                ready;
  logic [atc_pkg::STATUS_W-1:0]        status;
  logic [atc_pkg::COUNT_W-1:0]         live_count;
  logic [atc_pkg::WORD_W-1:0]          live_bytes;
  logic [atc_pkg::WORD_W-1:0]          peak_live_bytes;

  modport source (
    output valid, status, live_count, live_bytes, peak_live_bytes,
    input  ready
  );
  modport sink (
    input  valid, status, live_count, live_bytes, peak_live_bytes,
    output ready
  );
endinterface

// ===== hw/rtl/atc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module atc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/allocation_trace_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// allocation_trace_checker
// Checks allocator trace entries against a RAM table of live ids and sizes.
// ----------------------------------------------------------------------------
// Entries that need no table lookup go from accept through S_EVAL to
// S_RESP; allocate, free and reallocate also pass S_SCAN (one full walk of
// the table RAM, one read per cycle) and S_DECIDE. A start of trace adds an
// S_CLEAR pass over the table RAM first. One entry is in flight at a time.
// Reset: counters and flags clear at once, then a clearing pass runs over the
// table RAM before the first entry is accepted.
// ----------------------------------------------------------------------------
module allocation_trace_checker #(
  parameter int TABLE_DEPTH = atc_pkg::TABLE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  atc_in_if.sink          in_ch,
  atc_out_if.source       out_ch
);

  localparam int IW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW    = $clog2(TABLE_DEPTH + 1);
  localparam int EXT_W = CW + atc_pkg::COUNT_W;
  localparam int W     = atc_pkg::WORD_W;

  // sequencer and counters
  atc_pkg::state_t  state_r, state_nxt;
  logic [CW-1:0]    scan_cnt_r, scan_cnt_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  logic [IW-1:0]    rd_idx_r, rd_idx_nxt;

  // trace state
  logic [CW-1:0]    count_r, count_nxt;
  logic [W-1:0]     total_r, total_nxt;
  logic [W-1:0]     peak_r, peak_nxt;
  logic             failed_r, failed_nxt;

  // latched transaction
  logic [atc_pkg::OP_W-1:0]      it_op_r;
  logic [W-1:0]                  it_id_r;
  logic [W-1:0]                  it_size_r;
  logic [W-1:0]                  it_align_r;
  logic [atc_pkg::DOMAIN_W-1:0]  it_domain_r;

  // scan results
  logic             match_r, match_nxt;
  logic [IW-1:0]    match_idx_r, match_idx_nxt;
  logic [W-1:0]     total_less_r, total_less_nxt;
  logic             free_r, free_nxt;
  logic [IW-1:0]    free_idx_r, free_idx_nxt;

  atc_pkg::status_t status_r, status_nxt;

  // output register
  logic                         out_valid_r, out_valid_nxt;
  atc_pkg::status_t             out_status_r, out_status_nxt;
  logic [atc_pkg::COUNT_W-1:0]  out_count_r, out_count_nxt;
  logic [W-1:0]                 out_bytes_r, out_bytes_nxt;
  logic [W-1:0]                 out_peak_r, out_peak_nxt;

  // table RAM ports
  logic                  ram_we;
  logic [IW-1:0]         ram_waddr;
  atc_pkg::entry_t       ram_wdata;
  atc_pkg::entry_t       ram_rdata;

  logic                  accept;
  logic                  pre_fail;
  atc_pkg::status_t      pre_status;
  logic                  needs_table;
  logic                  out_free;
  logic [EXT_W-1:0]      count_ext;

  atc_ram #(
    .WIDTH ($bits(atc_pkg::entry_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (scan_cnt_r[IW-1:0]),
    .rdata (ram_rdata)
  );

  assign in_ch.ready = (state_r == atc_pkg::S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign count_ext   = EXT_W'(count_r);

  // table-free checks in priority order
  always_comb begin
    pre_fail   = 1'b1;
    pre_status = atc_pkg::ST_OK;
    priority if (it_id_r == '0) begin
      pre_status = atc_pkg::ST_ID_ZERO;
    end else if (it_op_r > atc_pkg::OP_MAX) begin
      pre_status = atc_pkg::ST_BAD_OP;
    end else if (it_domain_r > atc_pkg::DOMAIN_MAX) begin
      pre_status = atc_pkg::ST_BAD_DOMAIN;
    end else if ((it_op_r == atc_pkg::OP_ALLOC || it_op_r == atc_pkg::OP_REALLOC) &&
                 it_align_r != '0 &&
                 (it_align_r & (it_align_r - W'(1))) != '0) begin
      pre_status = atc_pkg::ST_BAD_ALIGN;
    end else begin
      pre_fail = 1'b0;
    end
  end

  assign needs_table = (it_op_r == atc_pkg::OP_ALLOC) || (it_op_r == atc_pkg::OP_FREE) ||
                       (it_op_r == atc_pkg::OP_REALLOC);

  // next state and datapath
  always_comb begin
    state_nxt      = state_r;
    scan_cnt_nxt   = scan_cnt_r;
    rd_vld_nxt     = 1'b0;
    rd_idx_nxt     = rd_idx_r;
    count_nxt      = count_r;
    total_nxt      = total_r;
    peak_nxt       = peak_r;
    failed_nxt     = failed_r;
    match_nxt      = match_r;
    match_idx_nxt  = match_idx_r;
    total_less_nxt = total_less_r;
    free_nxt       = free_r;
    free_idx_nxt   = free_idx_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    out_bytes_nxt  = out_bytes_r;
    out_peak_nxt   = out_peak_r;
    ram_we         = 1'b0;
    ram_waddr      = scan_cnt_r[IW-1:0];
    ram_wdata      = '0;

    unique case (state_r)
      // clearing pass after reset or at start of trace
      atc_pkg::S_INIT, atc_pkg::S_CLEAR: begin
        ram_we       = 1'b1;
        scan_cnt_nxt = scan_cnt_r + CW'(1);
        if (scan_cnt_r == CW'(TABLE_DEPTH - 1)) begin
          scan_cnt_nxt = '0;
          state_nxt    = (state_r == atc_pkg::S_INIT) ? atc_pkg::S_IDLE : atc_pkg::S_EVAL;
        end
      end

      // wait for a transaction
      atc_pkg::S_IDLE: begin
        if (accept) begin
          scan_cnt_nxt = '0;
          if (in_ch.start_of_trace) begin
            count_nxt  = '0;
            total_nxt  = '0;
            peak_nxt   = '0;
            failed_nxt = 1'b0;
            state_nxt  = atc_pkg::S_CLEAR;
          end else begin
            state_nxt  = atc_pkg::S_EVAL;
          end
        end
      end

      // skip, field checks, start the table walk, or pass a table-free entry as OK
      atc_pkg::S_EVAL: begin
        match_nxt = 1'b0;
        free_nxt  = 1'b0;
        if (failed_r) begin
          status_nxt = atc_pkg::ST_SKIPPED;
          state_nxt  = atc_pkg::S_RESP;
        end else if (pre_fail) begin
          status_nxt = pre_status;
          failed_nxt = 1'b1;
          state_nxt  = atc_pkg::S_RESP;
        end else if (needs_table) begin
          scan_cnt_nxt = '0;
          state_nxt    = atc_pkg::S_SCAN;
        end else begin
          status_nxt = atc_pkg::ST_OK;
          state_nxt  = atc_pkg::S_RESP;
        end
      end

      // walk the table: issue one read per cycle, compare the returning entry
      atc_pkg::S_SCAN: begin
        if (scan_cnt_r != CW'(TABLE_DEPTH)) begin
          scan_cnt_nxt = scan_cnt_r + CW'(1);
          rd_vld_nxt   = 1'b1;
          rd_idx_nxt   = scan_cnt_r[IW-1:0];
        end else if (!rd_vld_r) begin
          state_nxt = atc_pkg::S_DECIDE;
        end
        if (rd_vld_r) begin
          if (ram_rdata.valid && ram_rdata.id == it_id_r && !match_r) begin
            match_nxt      = 1'b1;
            match_idx_nxt  = rd_idx_r;
            total_less_nxt = total_r - ram_rdata.size;
          end
          if (!ram_rdata.valid && !free_r) begin
            free_nxt     = 1'b1;
            free_idx_nxt = rd_idx_r;
          end
        end
      end

      // liveness checks and table update
      atc_pkg::S_DECIDE: begin
        status_nxt = atc_pkg::ST_OK;
        state_nxt  = atc_pkg::S_RESP;
        unique case (it_op_r)
          atc_pkg::OP_ALLOC: begin
            if (match_r) begin
              status_nxt = atc_pkg::ST_DUPLICATE;
            end else if (!free_r) begin
              status_nxt = atc_pkg::ST_TABLE_FULL;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = free_idx_r;
              ram_wdata = '{valid: 1'b1, id: it_id_r, size: it_size_r};
              count_nxt = count_r + CW'(1);
              total_nxt = total_r + it_size_r;
            end
          end
          atc_pkg::OP_FREE: begin
            if (!match_r) begin
              status_nxt = atc_pkg::ST_FREE_NOT_LIVE;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = match_idx_r;
              ram_wdata = '0;
              count_nxt = count_r - CW'(1);
              total_nxt = total_less_r;
            end
          end
          default: begin
            if (!match_r) begin
              status_nxt = atc_pkg::ST_REALLOC_NOT_LIVE;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = match_idx_r;
              ram_wdata = '{valid: 1'b1, id: it_id_r, size: it_size_r};
              total_nxt = total_less_r + it_size_r;
            end
          end
        endcase
        if (status_nxt != atc_pkg::ST_OK) begin
          failed_nxt = 1'b1;
        end
      end

      // peak update and hand the result to the output register
      atc_pkg::S_RESP: begin
        if (out_free) begin
          peak_nxt       = (total_r > peak_r) ? total_r : peak_r;
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_count_nxt  = count_ext[atc_pkg::COUNT_W-1:0];
          out_bytes_nxt  = total_r;
          out_peak_nxt   = peak_nxt;
          state_nxt      = atc_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = atc_pkg::S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= atc_pkg::S_INIT;
      scan_cnt_r  <= '0;
      rd_vld_r    <= 1'b0;
      count_r     <= '0;
      total_r     <= '0;
      peak_r      <= '0;
      failed_r    <= 1'b0;
      match_r     <= 1'b0;
      free_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
      rd_vld_r    <= rd_vld_nxt;
      count_r     <= count_nxt;
      total_r     <= total_nxt;
      peak_r      <= peak_nxt;
      failed_r    <= failed_nxt;
      match_r     <= match_nxt;
      free_r      <= free_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      it_op_r     <= in_ch.opcode;
      it_id_r     <= in_ch.alloc_id;
      it_size_r   <= in_ch.block_size;
      it_align_r  <= in_ch.align_bytes;
      it_domain_r <= in_ch.memory_domain;
    end
    rd_idx_r     <= rd_idx_nxt;
    match_idx_r  <= match_idx_nxt;
    total_less_r <= total_less_nxt;
    free_idx_r   <= free_idx_nxt;
    status_r     <= status_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
    out_bytes_r  <= out_bytes_nxt;
    out_peak_r   <= out_peak_nxt;
  end

  // result channel
  assign out_ch.valid           = out_valid_r;
  assign out_ch.status          = out_status_r;
  assign out_ch.live_count      = out_count_r;
  assign out_ch.live_bytes      = out_bytes_r;
  assign out_ch.peak_live_bytes = out_peak_r;

endmodule
